/* hdl/eegp_pkg.sv */
// Package: shared types, codes and constants of the EEG headset packet parser.
`timescale 1ns / 1ps

package eegp_pkg;

    localparam logic [7:0] MAX_PAYLOAD     = 8'd169;
    localparam logic [7:0] SYNC_BYTE       = 8'hAA;
    localparam logic [7:0] CODE_SIGNAL     = 8'h02;
    localparam logic [7:0] CODE_ATTENTION  = 8'h04;
    localparam logic [7:0] CODE_MEDITATION = 8'h05;
    localparam logic [7:0] CODE_BLINK      = 8'h16;
    localparam logic [7:0] CODE_RAW        = 8'h80;
    localparam logic [7:0] CODE_POWERS     = 8'h83;
    localparam logic [7:0] POWERS_LEN      = 8'h18;
    localparam logic [7:0] RAW_LEN         = 8'h02;
    localparam logic [7:0] CODE_IGNORE     = 8'hFF;

    localparam int NUM_BANDS = 8;
    localparam int BAND_AW   = $clog2(NUM_BANDS);
    localparam logic [BAND_AW-1:0] LAST_BAND = BAND_AW'(NUM_BANDS - 1);

    localparam logic [5:0] SEEN_SIGNAL     = 6'h01;
    localparam logic [5:0] SEEN_POWERS     = 6'h02;
    localparam logic [5:0] SEEN_ATTENTION  = 6'h04;
    localparam logic [5:0] SEEN_MEDITATION = 6'h08;
    localparam logic [5:0] SEEN_BLINK      = 6'h10;
    localparam logic [5:0] SEEN_RAW        = 6'h20;

    typedef enum logic [2:0] {
        PH_SYNC1,
        PH_SYNC2,
        PH_LEN,
        PH_PAYLOAD,
        PH_CHECK
    } frame_phase_t;

    typedef enum logic [1:0] {
        RP_CODE,
        RP_VLEN,
        RP_VALUE
    } row_phase_t;

    typedef struct packed {
        logic                 we;
        logic [BAND_AW-1:0]   addr;
        logic [23:0]          data;
    } band_wr_t;

    typedef struct packed {
        logic        checksum_ok;
        logic [5:0]  present_mask;
        logic [7:0]  signal_quality;
        logic [7:0]  attention_level;
        logic [7:0]  meditation_level;
        logic [7:0]  blink_strength;
        logic [15:0] raw_sample;
    } snap_t;

    typedef struct packed {
        logic reads_busy;
        logic any_busy;
    } emit_status_t;

endpackage

/* hdl/eegp_byte_if.sv */
// Interface: byte input channel.
`timescale 1ns / 1ps

interface eegp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

/* hdl/eegp_result_if.sv */
// Interface: result output channel.
`timescale 1ns / 1ps

interface eegp_result_if;
    logic               valid;
    logic               ready;
    logic               checksum_ok;
    logic [5:0]         present_mask;
    logic [7:0]         signal_quality;
    logic [7:0]         attention_level;
    logic [7:0]         meditation_level;
    logic [7:0]         blink_strength;
    logic signed [15:0] raw_sample;
    logic [2:0]         band_index;
    logic [23:0]        band_power;
    logic               last_of_packet;

    modport source (
        output valid, output checksum_ok, output present_mask, output signal_quality,
        output attention_level, output meditation_level, output blink_strength,
        output raw_sample, output band_index, output band_power, output last_of_packet,
        input ready
    );
    modport sink (
        input valid, input checksum_ok, input present_mask, input signal_quality,
        input attention_level, input meditation_level, input blink_strength,
        input raw_sample, input band_index, input band_power, input last_of_packet,
        output ready
    );
endinterface

/* hdl/eegp_band_ram.sv */
// Band power memory: 8 x 24 bits, one write port, one registered read port.
`timescale 1ns / 1ps

module eegp_band_ram (
    input  logic                        clk,
    input  logic                        rst_n,
    input  eegp_pkg::band_wr_t          wr,
    input  logic                        re,
    input  logic [eegp_pkg::BAND_AW-1:0] raddr,
    output logic [23:0]                 rdata
);

    logic [23:0]                   mem [eegp_pkg::NUM_BANDS];
    logic [eegp_pkg::NUM_BANDS-1:0] valid_reg;
    logic [23:0]                   rdata_reg;

    // entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.we)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= valid_reg[raddr] ? mem[raddr] : 24'd0;
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/eegp_frame_parser.sv */
// Frame parser: sync hunt, length, row decoding, checksum and value holds.
`timescale 1ns / 1ps

module eegp_frame_parser (
    input  logic                   clk,
    input  logic                   rst_n,
    eegp_byte_if.sink              rx,
    input  eegp_pkg::emit_status_t st,
    output eegp_pkg::band_wr_t     bw,
    output logic                   snap_load,
    output eegp_pkg::snap_t        snap
);

    eegp_pkg::frame_phase_t       phase_reg, phase_next;
    eegp_pkg::row_phase_t         row_reg, row_next;
    logic [7:0]                   left_reg, left_next;
    logic [7:0]                   sum_reg, sum_next;
    logic [7:0]                   code_reg, code_next;
    logic [7:0]                   rbl_reg, rbl_next;
    logic [15:0]                  va_reg, va_next;
    logic [1:0]                   trip_reg, trip_next;
    logic [eegp_pkg::BAND_AW-1:0] bidx_reg, bidx_next;
    logic [5:0]                   seen_reg, seen_next;
    logic [7:0]                   qual_reg, qual_next;
    logic [7:0]                   att_reg, att_next;
    logic [7:0]                   med_reg, med_next;
    logic [7:0]                   blink_reg, blink_next;
    logic [15:0]                  raw_reg, raw_next;
    logic                         ready;
    logic                         accept;
    logic [7:0]                   b;

    assign b      = rx.rx_byte;
    assign accept = rx.valid && ready;
    assign rx.ready = ready;

    // payload waits for pending band reads; checksum waits for an idle emitter
    always_comb
    begin
        case (phase_reg)
            eegp_pkg::PH_PAYLOAD: ready = !st.reads_busy;
            eegp_pkg::PH_CHECK:   ready = !st.any_busy;
            default:              ready = 1'b1;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        row_next   = row_reg;
        left_next  = left_reg;
        sum_next   = sum_reg;
        code_next  = code_reg;
        rbl_next   = rbl_reg;
        va_next    = va_reg;
        trip_next  = trip_reg;
        bidx_next  = bidx_reg;
        seen_next  = seen_reg;
        qual_next  = qual_reg;
        att_next   = att_reg;
        med_next   = med_reg;
        blink_next = blink_reg;
        raw_next   = raw_reg;
        bw         = '0;
        snap_load  = 1'b0;

        snap.checksum_ok      = (~sum_reg == b);
        snap.present_mask     = seen_reg;
        snap.signal_quality   = qual_reg;
        snap.attention_level  = att_reg;
        snap.meditation_level = med_reg;
        snap.blink_strength   = blink_reg;
        snap.raw_sample       = raw_reg;

        if (accept)
        begin
            case (phase_reg)
                eegp_pkg::PH_SYNC1:
                begin
                    if (b == eegp_pkg::SYNC_BYTE)
                    begin
                        phase_next = eegp_pkg::PH_SYNC2;
                    end
                end
                eegp_pkg::PH_SYNC2:
                begin
                    phase_next = (b == eegp_pkg::SYNC_BYTE) ? eegp_pkg::PH_LEN
                                                            : eegp_pkg::PH_SYNC1;
                end
                eegp_pkg::PH_LEN:
                begin
                    if (b == eegp_pkg::SYNC_BYTE)
                    begin
                        phase_next = eegp_pkg::PH_LEN;
                    end
                    else if (b > eegp_pkg::MAX_PAYLOAD)
                    begin
                        phase_next = eegp_pkg::PH_SYNC1;
                    end
                    else
                    begin
                        left_next  = b;
                        sum_next   = 8'd0;
                        seen_next  = 6'd0;
                        row_next   = eegp_pkg::RP_CODE;
                        phase_next = (b == 8'd0) ? eegp_pkg::PH_CHECK
                                                 : eegp_pkg::PH_PAYLOAD;
                    end
                end
                eegp_pkg::PH_PAYLOAD:
                begin
                    sum_next  = sum_reg + b;
                    left_next = left_reg - 8'd1;
                    if (left_reg == 8'd1)
                    begin
                        phase_next = eegp_pkg::PH_CHECK;
                    end
                    case (row_reg)
                        eegp_pkg::RP_VLEN:
                        begin
                            rbl_next = b;
                            if ((code_reg == eegp_pkg::CODE_RAW && b != eegp_pkg::RAW_LEN) ||
                                (code_reg == eegp_pkg::CODE_POWERS &&
                                 b != eegp_pkg::POWERS_LEN))
                            begin
                                code_next = eegp_pkg::CODE_IGNORE;
                            end
                            row_next = (b == 8'd0) ? eegp_pkg::RP_CODE : eegp_pkg::RP_VALUE;
                        end
                        eegp_pkg::RP_VALUE:
                        begin
                            va_next  = {va_reg[7:0], b};
                            rbl_next = rbl_reg - 8'd1;
                            if (code_reg == eegp_pkg::CODE_POWERS)
                            begin
                                if (trip_reg == 2'd2)
                                begin
                                    bw.we     = 1'b1;
                                    bw.addr   = bidx_reg;
                                    bw.data   = {va_reg, b};
                                    trip_next = 2'd0;
                                    bidx_next = bidx_reg + 1'b1;
                                    if (bidx_reg == eegp_pkg::LAST_BAND)
                                    begin
                                        seen_next = seen_next | eegp_pkg::SEEN_POWERS;
                                    end
                                end
                                else
                                begin
                                    trip_next = trip_reg + 2'd1;
                                end
                            end
                            if (rbl_reg == 8'd1)
                            begin
                                case (code_reg)
                                    eegp_pkg::CODE_SIGNAL:
                                    begin
                                        qual_next = b;
                                        seen_next = seen_next | eegp_pkg::SEEN_SIGNAL;
                                    end
                                    eegp_pkg::CODE_ATTENTION:
                                    begin
                                        att_next  = b;
                                        seen_next = seen_next | eegp_pkg::SEEN_ATTENTION;
                                    end
                                    eegp_pkg::CODE_MEDITATION:
                                    begin
                                        med_next  = b;
                                        seen_next = seen_next | eegp_pkg::SEEN_MEDITATION;
                                    end
                                    eegp_pkg::CODE_BLINK:
                                    begin
                                        blink_next = b;
                                        seen_next  = seen_next | eegp_pkg::SEEN_BLINK;
                                    end
                                    eegp_pkg::CODE_RAW:
                                    begin
                                        raw_next  = {va_reg[7:0], b};
                                        seen_next = seen_next | eegp_pkg::SEEN_RAW;
                                    end
                                    default:
                                    begin
                                        seen_next = seen_next;
                                    end
                                endcase
                                row_next = eegp_pkg::RP_CODE;
                            end
                        end
                        default:
                        begin
                            code_next = b;
                            trip_next = 2'd0;
                            bidx_next = '0;
                            if (b >= eegp_pkg::CODE_RAW)
                            begin
                                row_next = eegp_pkg::RP_VLEN;
                            end
                            else
                            begin
                                rbl_next = 8'd1;
                                row_next = eegp_pkg::RP_VALUE;
                            end
                        end
                    endcase
                end
                eegp_pkg::PH_CHECK:
                begin
                    snap_load  = 1'b1;
                    phase_next = eegp_pkg::PH_SYNC1;
                end
                default:
                begin
                    phase_next = eegp_pkg::PH_SYNC1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= eegp_pkg::PH_SYNC1;
            row_reg   <= eegp_pkg::RP_CODE;
            left_reg  <= 8'd0;
            sum_reg   <= 8'd0;
            code_reg  <= 8'd0;
            rbl_reg   <= 8'd0;
            va_reg    <= 16'd0;
            trip_reg  <= 2'd0;
            bidx_reg  <= '0;
            seen_reg  <= 6'd0;
            qual_reg  <= 8'd0;
            att_reg   <= 8'd0;
            med_reg   <= 8'd0;
            blink_reg <= 8'd0;
            raw_reg   <= 16'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            row_reg   <= row_next;
            left_reg  <= left_next;
            sum_reg   <= sum_next;
            code_reg  <= code_next;
            rbl_reg   <= rbl_next;
            va_reg    <= va_next;
            trip_reg  <= trip_next;
            bidx_reg  <= bidx_next;
            seen_reg  <= seen_next;
            qual_reg  <= qual_next;
            att_reg   <= att_next;
            med_reg   <= med_next;
            blink_reg <= blink_next;
            raw_reg   <= raw_next;
        end
    end

endmodule

/* hdl/eegp_result_emitter.sv */
// Result emitter: reads the eight band powers and drives the result channel.
`timescale 1ns / 1ps

module eegp_result_emitter (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         snap_load,
    input  eegp_pkg::snap_t              snap,
    output eegp_pkg::emit_status_t       st,
    output logic                         re,
    output logic [eegp_pkg::BAND_AW-1:0] raddr,
    input  logic [23:0]                  rdata,
    eegp_result_if.source                res
);

    eegp_pkg::snap_t              snap_reg;
    logic                         rd_active_reg, rd_active_next;
    logic [eegp_pkg::BAND_AW-1:0] rd_idx_reg, rd_idx_next;
    logic                         r_v_reg, r_v_next;
    logic [eegp_pkg::BAND_AW-1:0] r_idx_reg;
    logic                         o_v_reg, o_v_next;
    logic [eegp_pkg::BAND_AW-1:0] o_idx_reg;
    logic [23:0]                  o_pow_reg;
    logic                         load_o;
    logic                         issue;

    assign load_o = r_v_reg && (!o_v_reg || res.ready);
    assign issue  = rd_active_reg && (!r_v_reg || load_o);
    assign re     = issue;
    assign raddr  = rd_idx_reg;

    assign st.reads_busy = rd_active_reg;
    assign st.any_busy   = rd_active_reg || r_v_reg || o_v_reg;

    always_comb
    begin
        rd_active_next = rd_active_reg;
        rd_idx_next    = rd_idx_reg;
        if (snap_load)
        begin
            rd_active_next = 1'b1;
            rd_idx_next    = '0;
        end
        else if (issue)
        begin
            rd_idx_next = rd_idx_reg + 1'b1;
            if (rd_idx_reg == eegp_pkg::LAST_BAND)
            begin
                rd_active_next = 1'b0;
            end
        end
        r_v_next = issue ? 1'b1 : (load_o ? 1'b0 : r_v_reg);
        o_v_next = load_o ? 1'b1 : (res.ready ? 1'b0 : o_v_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_active_reg <= 1'b0;
            rd_idx_reg    <= '0;
            r_v_reg       <= 1'b0;
            o_v_reg       <= 1'b0;
        end
        else
        begin
            rd_active_reg <= rd_active_next;
            rd_idx_reg    <= rd_idx_next;
            r_v_reg       <= r_v_next;
            o_v_reg       <= o_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (snap_load)
        begin
            snap_reg <= snap;
        end
        if (issue)
        begin
            r_idx_reg <= rd_idx_reg;
        end
        if (load_o)
        begin
            o_idx_reg <= r_idx_reg;
            o_pow_reg <= rdata;
        end
    end

    assign res.valid            = o_v_reg;
    assign res.checksum_ok      = snap_reg.checksum_ok;
    assign res.present_mask     = snap_reg.present_mask;
    assign res.signal_quality   = snap_reg.signal_quality;
    assign res.attention_level  = snap_reg.attention_level;
    assign res.meditation_level = snap_reg.meditation_level;
    assign res.blink_strength   = snap_reg.blink_strength;
    assign res.raw_sample       = $signed(snap_reg.raw_sample);
    assign res.band_index       = o_idx_reg;
    assign res.band_power       = o_pow_reg;
    assign res.last_of_packet   = (o_idx_reg == eegp_pkg::LAST_BAND);

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        snap_load |-> !(rd_active_reg || r_v_reg || o_v_reg))
        else $error("new packet result set while emitter busy");

    a_read_hold: assert property (@(posedge clk) disable iff (!rst_n)
        r_v_reg && !load_o |=> r_v_reg && $stable(r_idx_reg))
        else $error("read stage dropped while output stalled");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        load_o && o_v_reg && (o_idx_reg != eegp_pkg::LAST_BAND) |->
            r_idx_reg == o_idx_reg + 1'b1)
        else $error("band results out of order");

endmodule

/* hdl/eeg_headset_packet_parser_core.sv */
// Top level: EEG headset packet parser.
// Throughput: one received byte per cycle; payload bytes wait while band reads of the
// previous packet are still being issued, the checksum byte waits until all eight
// results of the previous packet have been transferred.
// Results: band reads start after the checksum byte transfer, then one per cycle while
// the sink is ready (bounded by the single read port of the band memory).
// Reset: asynchronous, active low; parser hunts for sync, holds and band powers read as zero.
`timescale 1ns / 1ps

module eeg_headset_packet_parser_core (
    input  logic          clk,
    input  logic          rst_n,
    eegp_byte_if.sink     rx,
    eegp_result_if.source res
);

    eegp_pkg::emit_status_t       st;
    eegp_pkg::band_wr_t           bw;
    eegp_pkg::snap_t              snap;
    logic                         snap_load;
    logic                         re;
    logic [eegp_pkg::BAND_AW-1:0] raddr;
    logic [23:0]                  rdata;

    eegp_frame_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx        (rx),
        .st        (st),
        .bw        (bw),
        .snap_load (snap_load),
        .snap      (snap)
    );

    eegp_band_ram u_ram (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (bw),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    eegp_result_emitter u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .snap_load (snap_load),
        .snap      (snap),
        .st        (st),
        .re        (re),
        .raddr     (raddr),
        .rdata     (rdata),
        .res       (res)
    );

endmodule

/* tb/sv/eeg_headset_packet_parser_checker.sv */
// Checker: tracks byte and result transfers, predicts band reports and compares them.
`timescale 1ns / 1ps

module eeg_headset_packet_parser_checker
    import eegp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    eegp_byte_if        rx,
    eegp_result_if      res,
    output int unsigned fail_count,
    output int unsigned reports_pending
);

    typedef struct packed {
        logic        ok;
        logic [5:0]  mask;
        logic [7:0]  quality;
        logic [7:0]  attention;
        logic [7:0]  meditation;
        logic [7:0]  blink;
        logic [15:0] raw;
        logic [2:0]  band;
        logic [23:0] power;
        logic        last;
    } band_report_t;

    band_report_t reports_due[$];

    frame_phase_t frame_st;
    row_phase_t   field_st;
    logic [7:0]   bytes_left;
    logic [7:0]   payload_sum;
    logic [7:0]   field_code;
    logic [7:0]   field_left;
    logic [4:0]   field_pos;
    logic [23:0]  shift_acc;
    logic [5:0]   seen;
    logic [7:0]   quality;
    logic [7:0]   attention;
    logic [7:0]   meditation;
    logic [7:0]   blink;
    logic [15:0]  raw;
    logic [23:0]  powers [NUM_BANDS];

    initial
    begin
        fail_count      = 0;
        reports_pending = 0;
    end

    task automatic clear_state();
        frame_st    = PH_SYNC1;
        field_st    = RP_CODE;
        bytes_left  = '0;
        payload_sum = '0;
        field_code  = '0;
        field_left  = '0;
        field_pos   = '0;
        shift_acc   = '0;
        seen        = '0;
        quality     = '0;
        attention   = '0;
        meditation  = '0;
        blink       = '0;
        raw         = '0;
        for (int i = 0; i < NUM_BANDS; i++)
        begin
            powers[i] = '0;
        end
    endtask

    task automatic parse_row_byte(input logic [7:0] b);
        case (field_st)
            RP_VLEN:
            begin
                field_left = b;
                if ((field_code == CODE_RAW && b != RAW_LEN) ||
                    (field_code == CODE_POWERS && b != POWERS_LEN))
                    field_code = CODE_IGNORE;
                field_st = (b == 8'h00) ? RP_CODE : RP_VALUE;
            end
            RP_VALUE:
            begin
                shift_acc  = {shift_acc[15:0], b};
                field_pos  = field_pos + 5'd1;
                field_left = field_left - 8'd1;
                if (field_code == CODE_POWERS && field_pos != 0 && field_pos <= 24 &&
                    field_pos % 3 == 0)
                begin
                    powers[3'(field_pos / 3 - 1)] = shift_acc;
                    shift_acc = '0;
                    if (field_pos == 24)
                        seen |= SEEN_POWERS;
                end
                if (field_left == 8'h00)
                begin
                    case (field_code)
                        CODE_SIGNAL:
                        begin
                            quality = b;
                            seen |= SEEN_SIGNAL;
                        end
                        CODE_ATTENTION:
                        begin
                            attention = b;
                            seen |= SEEN_ATTENTION;
                        end
                        CODE_MEDITATION:
                        begin
                            meditation = b;
                            seen |= SEEN_MEDITATION;
                        end
                        CODE_BLINK:
                        begin
                            blink = b;
                            seen |= SEEN_BLINK;
                        end
                        CODE_RAW:
                        begin
                            raw = shift_acc[15:0];
                            seen |= SEEN_RAW;
                        end
                        default:
                        begin
                        end
                    endcase
                    field_st = RP_CODE;
                end
            end
            default:
            begin
                field_code = b;
                field_pos  = '0;
                shift_acc  = '0;
                if (b >= CODE_RAW)
                    field_st = RP_VLEN;
                else
                begin
                    field_left = 8'd1;
                    field_st   = RP_VALUE;
                end
            end
        endcase
    endtask

    task automatic parse_byte(input logic [7:0] b);
        band_report_t rep;
        case (frame_st)
            PH_SYNC2:
                frame_st = (b == SYNC_BYTE) ? PH_LEN : PH_SYNC1;
            PH_LEN:
            begin
                if (b != SYNC_BYTE)
                begin
                    if (b > MAX_PAYLOAD)
                        frame_st = PH_SYNC1;
                    else
                    begin
                        bytes_left  = b;
                        payload_sum = '0;
                        seen        = '0;
                        field_st    = RP_CODE;
                        frame_st    = (b == 8'h00) ? PH_CHECK : PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                payload_sum = payload_sum + b;
                parse_row_byte(b);
                bytes_left = bytes_left - 8'd1;
                if (bytes_left == 8'h00)
                    frame_st = PH_CHECK;
            end
            PH_CHECK:
            begin
                for (int k = 0; k < NUM_BANDS; k++)
                begin
                    rep.ok         = (~payload_sum == b);
                    rep.mask       = seen;
                    rep.quality    = quality;
                    rep.attention  = attention;
                    rep.meditation = meditation;
                    rep.blink      = blink;
                    rep.raw        = raw;
                    rep.band       = 3'(k);
                    rep.power      = powers[k];
                    rep.last       = (3'(k) == LAST_BAND);
                    reports_due.push_back(rep);
                end
                frame_st = PH_SYNC1;
            end
            default:
                frame_st = (b == SYNC_BYTE) ? PH_SYNC2 : PH_SYNC1;
        endcase
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected 'h%0h, got 'h%0h", name, want, got);
            fail_count++;
        end
    endtask

    task automatic compare_report();
        band_report_t want;
        if (reports_due.size() == 0)
        begin
            $error("result transfer with no result expected");
            fail_count++;
            return;
        end
        want = reports_due.pop_front();
        check_field("checksum_ok", want.ok, res.checksum_ok);
        check_field("present_mask", want.mask, res.present_mask);
        check_field("signal_quality", want.quality, res.signal_quality);
        check_field("attention_level", want.attention, res.attention_level);
        check_field("meditation_level", want.meditation, res.meditation_level);
        check_field("blink_strength", want.blink, res.blink_strength);
        check_field("raw_sample", want.raw, $unsigned(res.raw_sample));
        check_field("band_index", want.band, res.band_index);
        check_field("band_power", want.power, res.band_power);
        check_field("last_of_packet", want.last, res.last_of_packet);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            clear_state();
            reports_due.delete();
        end
        else
        begin
            if (res.valid && res.ready)
                compare_report();
            if (rx.valid && rx.ready)
                parse_byte(rx.rx_byte);
        end
        reports_pending <= reports_due.size();
    end

endmodule

/* tb/sv/eeg_headset_packet_parser_core_tb.sv */
// Testbench top: clock, reset, byte stimulus, result back-pressure and verdict.
`timescale 1ns / 1ps

module eeg_headset_packet_parser_core_tb;
    import eegp_pkg::*;

    typedef logic [7:0] byte_q_t[$];

    localparam int unsigned CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    int unsigned cycle_count = 0;
    int unsigned fail_count;
    int unsigned reports_pending;
    int          src_idle_pct = 0;
    int          sink_stall_pct = 0;

    eegp_byte_if   rx_ch ();
    eegp_result_if res_ch ();

    eeg_headset_packet_parser_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch)
    );

    eeg_headset_packet_parser_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .rx              (rx_ch),
        .res             (res_ch),
        .fail_count      (fail_count),
        .reports_pending (reports_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        res_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    task automatic put_byte(input logic [7:0] b);
        if ($urandom_range(0, 99) < src_idle_pct)
        begin
            rx_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < src_idle_pct)
                @(posedge clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_packet(input byte_q_t payload, input bit good);
        logic [7:0] sum;
        sum = 8'h00;
        put_byte(SYNC_BYTE);
        put_byte(SYNC_BYTE);
        put_byte(8'(payload.size()));
        foreach (payload[i])
        begin
            sum += payload[i];
            put_byte(payload[i]);
        end
        put_byte(good ? ~sum : ~sum ^ 8'($urandom_range(1, 255)));
    endtask

    // pause the sender until every band report has been transferred
    task automatic wait_drained();
        rx_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (reports_pending != 0);
    endtask

    function automatic logic [7:0] power_byte();
        case ($urandom_range(0, 3))
            0:       return 8'hFF;
            1:       return 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic byte_q_t make_payload(input bit powers_pkt);
        byte_q_t q;
        int      n;
        q = {};
        if (powers_pkt)
        begin
            q.push_back(CODE_POWERS);
            q.push_back(POWERS_LEN);
            repeat (POWERS_LEN) q.push_back(power_byte());
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            repeat ($urandom_range(1, 12)) q.push_back(8'($urandom));
        end
        else
        begin
            repeat ($urandom_range(1, 2))
            begin
                case ($urandom_range(0, 9))
                    0: q.push_back(CODE_SIGNAL);
                    1: q.push_back(CODE_ATTENTION);
                    2: q.push_back(CODE_MEDITATION);
                    3: q.push_back(CODE_BLINK);
                    4:
                    begin
                        q.push_back(CODE_RAW);
                        q.push_back(RAW_LEN);
                        q.push_back(8'($urandom));
                    end
                    5:
                    begin
                        q.push_back(CODE_POWERS);
                        q.push_back(POWERS_LEN);
                        repeat (POWERS_LEN - 1) q.push_back(power_byte());
                    end
                    6: q.push_back(8'($urandom_range(0, CODE_RAW - 1)));
                    7:
                    begin
                        n = $urandom_range(0, 5);
                        q.push_back(8'($urandom_range(CODE_RAW, CODE_IGNORE)));
                        q.push_back(8'(n));
                        repeat (n) q.push_back(8'($urandom));
                        continue;
                    end
                    8:
                    begin
                        n = $urandom_range(0, 5);
                        if (n == RAW_LEN)
                            n = 1;
                        q.push_back(CODE_RAW);
                        q.push_back(8'(n));
                        repeat (n) q.push_back(8'($urandom));
                        continue;
                    end
                    default:
                    begin
                        n = $urandom_range(0, 6);
                        q.push_back(CODE_POWERS);
                        q.push_back(8'(n));
                        repeat (n) q.push_back(8'($urandom));
                        continue;
                    end
                endcase
                // final value byte of the row
                q.push_back(8'($urandom));
            end
            if ($urandom_range(0, 7) == 0 && q.size() > 1)
                repeat ($urandom_range(1, q.size() - 1)) q.pop_back();
        end
        while (q.size() > MAX_PAYLOAD)
            q.pop_back();
        return q;
    endfunction

    task automatic send_noise();
        case ($urandom_range(0, 2))
            0:
                repeat ($urandom_range(1, 3)) put_byte(8'($urandom));
            1:
            begin
                put_byte(SYNC_BYTE);
                put_byte(8'($urandom));
            end
            default:
            begin
                put_byte(SYNC_BYTE);
                put_byte(SYNC_BYTE);
                put_byte(8'($urandom_range(MAX_PAYLOAD + 1, 255)));
            end
        endcase
    endtask

    initial
    begin
        byte_q_t     pay;
        int          idle_by_phase [4];
        int          stall_by_phase [4];
        int unsigned packets;
        idle_by_phase  = '{0, 87, 0, 22};
        stall_by_phase = '{0, 0, 87, 22};
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = 8'h00;
        res_ch.ready  = 1'b0;
        rst_n         = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // broken sync, extra sync byte before an empty packet, oversize length
        put_byte(SYNC_BYTE);
        put_byte(8'h55);
        put_byte(SYNC_BYTE);
        pay = {};
        send_packet(pay, 1'b1);
        put_byte(SYNC_BYTE);
        put_byte(SYNC_BYTE);
        put_byte(MAX_PAYLOAD + 8'd1);
        // every single-byte row, raw at its minimum, short and bad-length rows
        pay = {CODE_SIGNAL, 8'd200, CODE_ATTENTION, 8'hFF, CODE_MEDITATION, 8'h00,
               CODE_BLINK, 8'h7F, CODE_RAW, RAW_LEN, 8'h80, 8'h00, 8'h55, 8'h12,
               CODE_POWERS, 8'h00, CODE_RAW, 8'h03, 8'h01, 8'h02, 8'h03};
        send_packet(pay, 1'b1);
        // raw at its maximum, row cut off by payload end, bad checksum
        pay = {CODE_RAW, RAW_LEN, 8'h7F, 8'hFF, 8'h81, 8'h05, 8'h01};
        send_packet(pay, 1'b0);
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            src_idle_pct   <= idle_by_phase[ph];
            sink_stall_pct <= stall_by_phase[ph];
            packets = 0;
            while (packets < 2)
            begin
                if ($urandom_range(0, 5) == 0)
                    send_noise();
                pay = make_payload(ph == 0 && packets == 0);
                send_packet(pay, $urandom_range(0, 99) < 85);
                packets++;
            end
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
